// ===== rtl/fcc_pkg.sv =====
// ----------------------------------------------------------------------------
// fcc_pkg
// Shared types and constants for the frame checksum checker.
// ----------------------------------------------------------------------------
package fcc_pkg;

    // Field widths
    localparam int unsigned ByteW  = 8;
    localparam int unsigned SumW   = 16;
    localparam int unsigned CountW = 17;
    localparam int unsigned AddrW  = 4;
    localparam int unsigned DataW  = 32;

    // Byte counter saturates here
    localparam logic [CountW-1:0] CountMax = 17'h10000;

    // Register reset values
    localparam logic [ByteW-1:0] HdrFirstRst  = 8'h5A;
    localparam logic [ByteW-1:0] HdrSecondRst = 8'hA5;
    localparam logic [SumW-1:0]  MinLenRst    = 16'd12;

    // Register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_HDR_FIRST  = 2'd0,
        REG_HDR_SECOND = 2'd1,
        REG_MIN_LENGTH = 2'd2
    } t_reg_idx;

    // Verdict codes
    typedef enum logic [2:0] {
        FAIL_NONE     = 3'd0,
        FAIL_SHORT    = 3'd1,
        FAIL_HEADER   = 3'd2,
        FAIL_LENGTH   = 3'd3,
        FAIL_CHECKSUM = 3'd4
    } t_reason;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [ByteW-1:0] hdr_first;
        logic [ByteW-1:0] hdr_second;
        logic [SumW-1:0]  min_length;
    } t_cfg;

    // One result item
    typedef struct packed {
        logic              frame_ok;
        t_reason           reason;
        logic [CountW-1:0] frame_bytes;
    } t_result;

endpackage

// ===== rtl/frame_checksum_checker.sv =====
// ----------------------------------------------------------------------------
// frame_checksum_checker
// Byte-stream frame checker: min length, header, length field, sum16.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle while not stalled, and registers the
// verdict of the last byte before its request on the result channel. Each
// byte updates the frame state through combinational logic (a 16-bit add
// and a few compares); the verdict is captured straight into a two-entry
// output buffer, and the input stalls only when both entries are full.
// Checks run in order: too short, bad header, length mismatch, checksum
// mismatch; the last two bytes are an unchecked trailer. Header bytes and
// the minimum length are set through the APB port and should be changed
// only between frames.
module frame_checksum_checker
    import fcc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [AddrW-1:0]  paddr,
    input  logic [DataW-1:0]  pwdata,
    output logic [DataW-1:0]  prdata,
    output logic              pready,
    // byte input
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [ByteW-1:0]  i_rx_byte,
    input  logic              i_last_byte,
    // result output
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_frame_ok,
    output logic [2:0]        o_fail_reason,
    output logic [CountW-1:0] o_frame_bytes
);

    t_cfg    cfg;
    logic    accept;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign accept = i_in_valid & o_in_ready;

    fcc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fcc_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .i_last_byte (i_last_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    fcc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (res),
        .o_space (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (out_res)
    );

    assign o_frame_ok    = out_res.frame_ok;
    assign o_fail_reason = out_res.reason;
    assign o_frame_bytes = out_res.frame_bytes;

endmodule

// ===== rtl/fcc_regs.sv =====
// ----------------------------------------------------------------------------
// fcc_regs
// APB-style configuration registers: header bytes and minimum length.
// ----------------------------------------------------------------------------
module fcc_regs
    import fcc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    logic [ByteW-1:0] r_hdr_first;
    logic [ByteW-1:0] r_hdr_second;
    logic [SumW-1:0]  r_min_length;
    logic             wr_en;
    t_reg_idx         reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_first  <= HdrFirstRst;
            r_hdr_second <= HdrSecondRst;
            r_min_length <= MinLenRst;
        end else if (wr_en) begin
            case (reg_idx)
                REG_HDR_FIRST:  r_hdr_first  <= pwdata[ByteW-1:0];
                REG_HDR_SECOND: r_hdr_second <= pwdata[ByteW-1:0];
                REG_MIN_LENGTH: r_min_length <= pwdata[SumW-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (reg_idx)
            REG_HDR_FIRST:  prdata = {{(DataW-ByteW){1'b0}}, r_hdr_first};
            REG_HDR_SECOND: prdata = {{(DataW-ByteW){1'b0}}, r_hdr_second};
            REG_MIN_LENGTH: prdata = {{(DataW-SumW){1'b0}}, r_min_length};
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = '{hdr_first: r_hdr_first, hdr_second: r_hdr_second,
                     min_length: r_min_length};

endmodule

// ===== rtl/fcc_frame.sv =====
// ----------------------------------------------------------------------------
// fcc_frame
// Per-frame state: byte count, header flag, length and checksum fields,
// two-byte trailer delay and running sum. Produces the verdict on the
// last byte.
// ----------------------------------------------------------------------------
module fcc_frame
    import fcc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_accept,
    input  logic [ByteW-1:0] i_rx_byte,
    input  logic             i_last_byte,
    output logic             o_res_valid,
    output t_result          o_res
);

    logic [CountW-1:0] r_byte_count, n_byte_count;
    logic [SumW-1:0]   r_running_sum, n_running_sum;
    logic [ByteW-1:0]  r_held0, r_held1;
    logic              r_header_good, n_header_good;
    logic [SumW-1:0]   r_length_field, n_length_field;
    logic [SumW-1:0]   r_sum_field, n_sum_field;
    logic              add_en;
    t_reason           reason;

    // Next state for this byte; k is the current count
    always_comb begin
        n_header_good  = r_header_good;
        n_length_field = r_length_field;
        n_sum_field    = r_sum_field;
        if (r_byte_count == 17'd0 && i_rx_byte != i_cfg.hdr_first)
            n_header_good = 1'b0;
        if (r_byte_count == 17'd1 && i_rx_byte != i_cfg.hdr_second)
            n_header_good = 1'b0;
        if (r_byte_count == 17'd2) n_length_field[7:0]  = i_rx_byte;
        if (r_byte_count == 17'd3) n_length_field[15:8] = i_rx_byte;
        if (r_byte_count == 17'd4) n_sum_field[7:0]     = i_rx_byte;
        if (r_byte_count == 17'd5) n_sum_field[15:8]    = i_rx_byte;
    end

    // Oldest held byte joins the sum, except the checksum bytes themselves
    assign add_en = (r_byte_count >= 17'd2) && (r_byte_count != 17'd6)
                 && (r_byte_count != 17'd7);
    assign n_running_sum = add_en ? r_running_sum + {{(SumW-ByteW){1'b0}}, r_held1}
                                  : r_running_sum;
    assign n_byte_count  = (r_byte_count == CountMax) ? r_byte_count
                                                      : r_byte_count + 17'd1;

    // Verdict, first failing check wins
    always_comb begin
        if (n_byte_count <= {1'b0, i_cfg.min_length})
            reason = FAIL_SHORT;
        else if (!n_header_good || n_byte_count < 17'd2)
            reason = FAIL_HEADER;
        else if ({1'b0, n_length_field} != n_byte_count)
            reason = FAIL_LENGTH;
        else if (n_sum_field != n_running_sum)
            reason = FAIL_CHECKSUM;
        else
            reason = FAIL_NONE;
    end

    assign o_res_valid = i_accept & i_last_byte;
    assign o_res       = '{frame_ok: (reason == FAIL_NONE), reason: reason,
                           frame_bytes: n_byte_count};

    // State update; the last byte returns everything to its start value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_byte)) begin
            r_byte_count   <= '0;
            r_running_sum  <= '0;
            r_held0        <= '0;
            r_held1        <= '0;
            r_header_good  <= 1'b1;
            r_length_field <= '0;
            r_sum_field    <= '0;
        end else if (i_accept) begin
            r_byte_count   <= n_byte_count;
            r_running_sum  <= n_running_sum;
            r_held0        <= i_rx_byte;
            r_held1        <= r_held0;
            r_header_good  <= n_header_good;
            r_length_field <= n_length_field;
            r_sum_field    <= n_sum_field;
        end
    end

endmodule

// ===== rtl/fcc_out_buf.sv =====
// ----------------------------------------------------------------------------
// fcc_out_buf
// Two-entry result buffer: output register plus skid register, so the
// input side never waits on o_out_valid/i_out_ready combinationally.
// ----------------------------------------------------------------------------
module fcc_out_buf
    import fcc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_main_valid, r_skid_valid;
    t_result r_main, r_skid;
    logic    pop;

    assign pop     = r_main_valid & i_ready;
    assign o_space = ~r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_res   = r_main;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_main_valid <= 1'b1;
            r_skid_valid <= r_main_valid & ~pop;
        end else if (pop) begin
            r_main_valid <= r_skid_valid;
            r_skid_valid <= 1'b0;
        end
    end

    // Payload, push only happens while the skid slot is empty
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            if (!r_main_valid || pop) r_main <= i_res;
            else                      r_skid <= i_res;
        end else if (pop) begin
            r_main <= r_skid;
        end
    end

endmodule

// ===== tb/tb_frame_checksum_checker.sv =====
// ----------------------------------------------------------------------------
// tb_frame_checksum_checker
// Self-checking bench for the byte-stream frame checker.
// ----------------------------------------------------------------------------
// Builds frames, most of them well formed and some with a damaged header,
// length or checksum, and streams them byte by byte. A cycle-level predictor
// tracks each accepted byte and queues the verdict for every last byte. The
// monitor compares each result request field by field against that queue.
// Both sides idle at random. One long receiver hold-off backs the block up.
// Register settings change between phases, including the extremes.
// ----------------------------------------------------------------------------
module tb_frame_checksum_checker;
    import fcc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CycleLimit  = 1_000_000;
    localparam int unsigned HoldCycles  = 400;
    localparam int unsigned SettleDelay = 4;

    // Ways a generated frame is spoiled
    typedef enum logic [2:0] {
        DMG_NONE,
        DMG_HEADER,
        DMG_LENGTH,
        DMG_SUM,
        DMG_NOISE
    } t_damage;

    // One byte request as it goes on the wire
    typedef struct packed {
        logic [ByteW-1:0] data;
        logic             is_last;
    } t_wire_byte;

    // DUT signals
    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [AddrW-1:0]  paddr         = '0;
    logic [DataW-1:0]  pwdata        = '0;
    logic [DataW-1:0]  prdata;
    logic              pready;
    logic              i_in_valid    = 1'b0;
    logic              o_in_ready;
    logic [ByteW-1:0]  i_rx_byte     = '0;
    logic              i_last_byte   = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready   = 1'b0;
    logic              o_frame_ok;
    logic [2:0]        o_fail_reason;
    logic [CountW-1:0] o_frame_bytes;

    // Register shadow
    logic [ByteW-1:0]  cfg_hdr_first  = HdrFirstRst;
    logic [ByteW-1:0]  cfg_hdr_second = HdrSecondRst;
    logic [SumW-1:0]   cfg_min_len    = MinLenRst;

    // Predicted frame state
    logic [CountW-1:0] rx_count   = '0;
    logic [SumW-1:0]   rx_sum     = '0;
    logic [ByteW-1:0]  delay_new  = '0;
    logic [ByteW-1:0]  delay_old  = '0;
    logic              hdr_ok     = 1'b1;
    logic [SumW-1:0]   len_fld    = '0;
    logic [SumW-1:0]   sum_fld    = '0;

    // Byte stream and verdict bookkeeping
    t_wire_byte  pending_bytes[$];
    t_result     verdicts[$];
    t_wire_byte  next_byte;
    t_result     oldest;
    int unsigned queued_bytes   = 0;
    int unsigned accepted_bytes = 0;
    int unsigned mismatches     = 0;
    int unsigned cycle_count    = 0;

    // Idling control
    logic        in_taken  = 1'b0;
    logic        hold_req  = 1'b0;
    logic        hold_done = 1'b0;
    int unsigned hold_left = 0;
    int unsigned tx_gap    = 0;
    int unsigned tx_quiet  = 0;
    int unsigned rx_stall  = 0;
    int unsigned rx_quiet  = 0;

    frame_checksum_checker uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_rx_byte     (i_rx_byte),
        .i_last_byte   (i_last_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_frame_ok    (o_frame_ok),
        .o_fail_reason (o_fail_reason),
        .o_frame_bytes (o_frame_bytes)
    );

    always #5 i_clk = ~i_clk;

    // Mostly back to back, sometimes a short gap, rarely a long gap
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        else if (r < 92) return $urandom_range(1, 3);
        else return $urandom_range(8, 40);
    endfunction

    // Advance the frame state by one byte; queue a verdict on the last one
    task automatic track_byte(input logic [ByteW-1:0] b, input logic is_last);
        logic [CountW-1:0] k;
        t_result           v;
        k = rx_count;
        if (k == 0 && b != cfg_hdr_first) hdr_ok = 1'b0;
        if (k == 1 && b != cfg_hdr_second) hdr_ok = 1'b0;
        if (k == 2) len_fld[7:0] = b;
        if (k == 3) len_fld[15:8] = b;
        if (k == 4) sum_fld[7:0] = b;
        if (k == 5) sum_fld[15:8] = b;
        // byte k-2 leaves the delay line; the checksum bytes are skipped
        if (k >= 2 && k != 6 && k != 7) rx_sum = rx_sum + delay_old;
        delay_old = delay_new;
        delay_new = b;
        if (rx_count < CountMax) rx_count = rx_count + 1'b1;
        if (is_last) begin
            if (rx_count <= {1'b0, cfg_min_len}) v.reason = FAIL_SHORT;
            else if (!hdr_ok || rx_count < 2) v.reason = FAIL_HEADER;
            else if ({1'b0, len_fld} != rx_count) v.reason = FAIL_LENGTH;
            else if (sum_fld != rx_sum) v.reason = FAIL_CHECKSUM;
            else v.reason = FAIL_NONE;
            v.frame_ok = (v.reason == FAIL_NONE);
            v.frame_bytes = rx_count;
            verdicts.push_back(v);
            rx_count  = '0;
            rx_sum    = '0;
            delay_new = '0;
            delay_old = '0;
            hdr_ok    = 1'b1;
            len_fld   = '0;
            sum_fld   = '0;
        end
    endtask

    // APB write; upper bits beyond the register width carry junk
    task automatic write_reg(input t_reg_idx idx, input logic [SumW-1:0] val);
        logic [DataW-1:0] junk;
        junk = $urandom;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        case (idx)
            REG_MIN_LENGTH: pwdata <= {junk[DataW-1:SumW], val};
            default:        pwdata <= {junk[DataW-1:ByteW], val[ByteW-1:0]};
        endcase
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_HDR_FIRST:  cfg_hdr_first  = val[ByteW-1:0];
            REG_HDR_SECOND: cfg_hdr_second = val[ByteW-1:0];
            REG_MIN_LENGTH: cfg_min_len    = val;
            default: ;
        endcase
    endtask

    // Build one frame against the current register settings
    task automatic queue_frame(input int unsigned len, input t_damage dmg);
        logic [ByteW-1:0] body[];
        logic [SumW-1:0]  sum;
        t_wire_byte       wb;
        int unsigned      pos;
        body = new[len];
        foreach (body[i]) body[i] = $urandom_range(0, 255);
        if (dmg != DMG_NOISE) begin
            if (len > 0) body[0] = cfg_hdr_first;
            if (len > 1) body[1] = cfg_hdr_second;
            if (len > 2) body[2] = len[7:0];
            if (len > 3) body[3] = len[15:8];
            sum = '0;
            for (int i = 0; i + 2 < len; i++)
                if (i != 4 && i != 5) sum = sum + body[i];
            if (len > 4) body[4] = sum[7:0];
            if (len > 5) body[5] = sum[15:8];
            case (dmg)
                DMG_HEADER: begin
                    pos = (len > 1) ? $urandom_range(0, 1) : 0;
                    body[pos] = body[pos] ^ (8'h01 << $urandom_range(0, 7));
                end
                DMG_LENGTH: begin
                    if (len > 2) begin
                        pos = (len > 3) ? $urandom_range(2, 3) : 2;
                        body[pos] = body[pos] ^ (8'h01 << $urandom_range(0, 7));
                    end
                end
                DMG_SUM: begin
                    if (len > 4) begin
                        pos = (len > 5) ? $urandom_range(4, 5) : 4;
                        body[pos] = body[pos] ^ (8'h01 << $urandom_range(0, 7));
                    end
                end
                default: ;
            endcase
        end
        for (int i = 0; i < len; i++) begin
            wb.data    = body[i];
            wb.is_last = (i == len - 1);
            pending_bytes.push_back(wb);
        end
        queued_bytes += len;
    endtask

    // Random frames until the byte budget is spent; lo must be at least 1
    task automatic queue_phase(input int unsigned budget, input int unsigned lo,
                               input int unsigned hi);
        int unsigned used;
        int unsigned len;
        int unsigned pick;
        t_damage     dmg;
        used = 0;
        while (used < budget) begin
            len  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, hi)
                                                : $urandom_range(lo, hi);
            pick = $urandom_range(0, 99);
            if (pick < 70) dmg = DMG_NONE;
            else if (pick < 78) dmg = DMG_HEADER;
            else if (pick < 86) dmg = DMG_LENGTH;
            else if (pick < 94) dmg = DMG_SUM;
            else dmg = DMG_NOISE;
            queue_frame(len, dmg);
            used += len;
        end
    endtask

    // Wait until every byte is taken and every verdict has come back
    task automatic settle();
        @(negedge i_clk);
        while (accepted_bytes != queued_bytes || verdicts.size() != 0)
            @(negedge i_clk);
        repeat (SettleDelay) @(negedge i_clk);
    endtask

    // Byte driver: next request once the previous one is taken
    always @(negedge i_clk) begin
        if (!i_in_valid || in_taken) begin
            if (tx_gap > 0) begin
                tx_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                next_byte = pending_bytes.pop_front();
                i_rx_byte   <= next_byte.data;
                i_last_byte <= next_byte.is_last;
                i_in_valid  <= 1'b1;
                if (tx_quiet > 0) begin
                    tx_quiet--;
                    tx_gap = 0;
                end else begin
                    tx_gap = idle_len();
                    if ($urandom_range(0, 63) == 0) tx_quiet = $urandom_range(40, 160);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, quiet stretches, one long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HoldCycles - 1;
            i_out_ready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (rx_quiet > 0) begin
                rx_quiet--;
            end else begin
                if ($urandom_range(0, 3) == 0) rx_stall = idle_len();
                if ($urandom_range(0, 63) == 0) rx_quiet = $urandom_range(40, 160);
            end
        end
    end

    // Monitor: predict on byte requests, check result requests
    always @(posedge i_clk) begin
        in_taken <= i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                accepted_bytes++;
                track_byte(i_rx_byte, i_last_byte);
            end
            if (o_out_valid && i_out_ready) begin
                if (verdicts.size() == 0) begin
                    $display("%0t: unexpected result ok=%0d reason=%0d bytes=%0d",
                             $time, o_frame_ok, o_fail_reason, o_frame_bytes);
                    mismatches++;
                end else begin
                    oldest = verdicts.pop_front();
                    if (o_frame_ok !== oldest.frame_ok) begin
                        $display("%0t: frame_ok expected %0d, actual %0d",
                                 $time, oldest.frame_ok, o_frame_ok);
                        mismatches++;
                    end
                    if (o_fail_reason !== oldest.reason) begin
                        $display("%0t: fail_reason expected %0d, actual %0d",
                                 $time, oldest.reason, o_fail_reason);
                        mismatches++;
                    end
                    if (o_frame_bytes !== oldest.frame_bytes) begin
                        $display("%0t: frame_bytes expected %0d, actual %0d",
                                 $time, oldest.frame_bytes, o_frame_bytes);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("[frame_checksum_checker] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: good frame, then a one-byte frame that is too short
        queue_frame(13, DMG_NONE);
        queue_frame(1, DMG_NONE);
        settle();

        // Zero headers, no minimum: header incomplete, missing length field,
        // missing checksum bytes that still pass, and a bad checksum
        write_reg(REG_HDR_FIRST, 16'h0000);
        write_reg(REG_HDR_SECOND, 16'h0000);
        write_reg(REG_MIN_LENGTH, 16'd0);
        queue_frame(1, DMG_NONE);
        queue_frame(2, DMG_NONE);
        queue_frame(4, DMG_NONE);
        queue_frame(6, DMG_SUM);
        settle();

        write_reg(REG_HDR_FIRST, 16'h00FF);
        write_reg(REG_MIN_LENGTH, 16'd6);
        queue_phase(300, 7, 40);
        settle();

        // Tiny frames while the receiver holds off, so the block backs up
        write_reg(REG_HDR_FIRST, 16'h0000);
        write_reg(REG_HDR_SECOND, 16'h00FF);
        write_reg(REG_MIN_LENGTH, 16'd0);
        hold_req = 1'b1;
        queue_phase(300, 1, 10);
        settle();

        // Largest minimum: everything is too short
        write_reg(REG_MIN_LENGTH, 16'hFFFF);
        queue_phase(100, 5, 30);
        settle();

        write_reg(REG_HDR_FIRST, 16'($urandom_range(0, 255)));
        write_reg(REG_HDR_SECOND, 16'($urandom_range(0, 255)));
        write_reg(REG_MIN_LENGTH, 16'($urandom_range(0, 20)));
        queue_phase(300, cfg_min_len + 1, cfg_min_len + 30);
        settle();

        write_reg(REG_HDR_FIRST, 16'(HdrFirstRst));
        write_reg(REG_HDR_SECOND, 16'(HdrSecondRst));
        write_reg(REG_MIN_LENGTH, MinLenRst);
        queue_phase(300, 13, 45);
        settle();

        write_reg(REG_HDR_FIRST, 16'($urandom_range(0, 255)));
        write_reg(REG_HDR_SECOND, 16'($urandom_range(0, 255)));
        write_reg(REG_MIN_LENGTH, 16'd30);
        queue_phase(300, 31, 60);
        settle();

        if (mismatches == 0 && verdicts.size() == 0) begin
            $display("[frame_checksum_checker] OK");
        end else begin
            $display("[frame_checksum_checker] ERROR");
        end
        $finish;
    end

endmodule
